// ===== rtl/core/fnvh_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvh_pkg
// Shared types and constants of the FNV-1a 64-bit field hasher.
// ----------------------------------------------------------------------------
package fnvh_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int FIELD_LEN_W = 32;
  localparam int LEN_BYTES   = 8;
  localparam int LEN_CNT_W   = $clog2(LEN_BYTES);

  // Only the low LENGTH_BITS bits of the announced length are framed.
  localparam logic [FIELD_LEN_W-1:0] LEN_MASK =
    (LENGTH_BITS >= FIELD_LEN_W) ? '1 :
    FIELD_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // FNV prime 0x00000100000001B3 = 2^40 + 0x1B3.
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1B3;

  localparam logic [7:0] TAG_ABSENT  = 8'h00;
  localparam logic [7:0] TAG_PRESENT = 8'h01;

  typedef enum logic [2:0] {
    MODE_RESTART = 3'd0,
    MODE_RESTORE = 3'd1,
    MODE_SAVE    = 3'd2,
    MODE_ABSENT  = 3'd3,
    MODE_PRESENT = 3'd4,
    MODE_PLAIN   = 3'd5,
    MODE_DATA    = 3'd6
  } mode_t;

  // Per-cycle commands from the sequencer to the hash registers.
  typedef struct packed {
    logic mix;
    logic load_basis;
    logic load_saved;
    logic save;
    logic finish;
  } ctl_t;

endpackage

// ===== rtl/core/fnvh_mix.sv =====
// ----------------------------------------------------------------------------
// fnvh_mix
// One FNV-1a round: xor a byte into the hash, multiply by the prime mod 2^64.
// ----------------------------------------------------------------------------
module fnvh_mix (
  input  logic [63:0] hash_in,
  input  logic [7:0]  round_byte,
  output logic [63:0] hash_out
);

  logic [63:0] x;
  logic [63:0] low_prod;

  assign x        = hash_in ^ {56'd0, round_byte};
  // prime = 2^40 + 0x1B3: one shift plus a narrow constant product
  assign low_prod = x * 64'(fnvh_pkg::FNV_PRIME_LOW);
  assign hash_out = (x << fnvh_pkg::FNV_PRIME_SHIFT) + low_prod;

endmodule

// ===== rtl/core/fnvh_seq.sv =====
// ----------------------------------------------------------------------------
// fnvh_seq
// Request decoder and length-prefix sequencer driving the shared mix round.
// ----------------------------------------------------------------------------
module fnvh_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [2:0]                         mode,
  input  logic [fnvh_pkg::FIELD_LEN_W-1:0]   field_length,
  input  logic [7:0]                         data_byte,
  output logic                               idle,
  output fnvh_pkg::ctl_t                     ctl,
  output logic [7:0]                         round_byte
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LEN  = 2'b10
  } state_t;

  state_t                              state, state_next;
  logic [fnvh_pkg::LEN_CNT_W-1:0]      cnt, cnt_next;
  logic [fnvh_pkg::FIELD_LEN_W-1:0]    len_sr, len_sr_next;

  assign idle = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    len_sr_next = len_sr;
    ctl         = '0;
    round_byte  = data_byte;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (fnvh_pkg::mode_t'(mode))
            fnvh_pkg::MODE_RESTART: begin
              ctl.load_basis = 1'b1;
              ctl.finish     = 1'b1;
            end
            fnvh_pkg::MODE_RESTORE: begin
              ctl.load_saved = 1'b1;
              ctl.finish     = 1'b1;
            end
            fnvh_pkg::MODE_SAVE: begin
              ctl.save   = 1'b1;
              ctl.finish = 1'b1;
            end
            fnvh_pkg::MODE_ABSENT: begin
              ctl.mix    = 1'b1;
              round_byte = fnvh_pkg::TAG_ABSENT;
              ctl.finish = 1'b1;
            end
            fnvh_pkg::MODE_PRESENT: begin
              ctl.mix     = 1'b1;
              round_byte  = fnvh_pkg::TAG_PRESENT;
              state_next  = ST_LEN;
              cnt_next    = '0;
              len_sr_next = field_length & fnvh_pkg::LEN_MASK;
            end
            fnvh_pkg::MODE_PLAIN: begin
              state_next  = ST_LEN;
              cnt_next    = '0;
              len_sr_next = field_length & fnvh_pkg::LEN_MASK;
            end
            fnvh_pkg::MODE_DATA: begin
              ctl.mix    = 1'b1;
              ctl.finish = 1'b1;
            end
            default: begin
              // unused mode: hash unchanged, result still returned
              ctl.finish = 1'b1;
            end
          endcase
        end
      end
      ST_LEN: begin
        // mix length bytes low first; upper bytes shift in as zeros
        ctl.mix     = 1'b1;
        round_byte  = len_sr[7:0];
        len_sr_next = len_sr >> 8;
        cnt_next    = cnt + 1'b1;
        if (cnt == fnvh_pkg::LEN_CNT_W'(fnvh_pkg::LEN_BYTES - 1)) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    len_sr <= len_sr_next;
  end

endmodule

// ===== rtl/core/fnv1a64_field_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// fnv1a64_field_hasher_unit
// Streaming 64-bit FNV-1a hasher with tagged, length-prefixed field framing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (mode, field_length, data_byte) and each
//   one returns the running 64-bit hash on the m_ channel.
//   Restart, restore, save, absent-field and data-byte requests complete on
//   acceptance: the result is valid the cycle after acceptance, and back-to-back
//   requests run at one per cycle while the receiver keeps m_tready high.
//   Present and plain field headers mix eight length bytes, one per cycle on
//   the single shared mix round; the result is returned once the last length
//   byte is mixed, and s_tready stays low while the length bytes are mixed.
//   The hash register and the checkpoint reset to the FNV offset basis.
//   A result waits in the output register while m_tready is low; a new
//   request is accepted only once that register drains or is drained in the
//   same cycle, so no result is lost or overwritten.
// ----------------------------------------------------------------------------
module fnv1a64_field_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // mode[2:0], field_length[34:3], data_byte[42:35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // hash_value[63:0]
);

  logic                                idle;
  logic                                accept;
  fnvh_pkg::ctl_t                      ctl;
  logic [7:0]                          round_byte;
  logic [63:0]                         hash_state, hash_next;
  logic [63:0]                         saved_base, saved_base_next;
  logic [63:0]                         mix_out;
  logic [63:0]                         hash_out;

  assign s_tready = idle && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  fnvh_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (s_tdata[2:0]),
    .field_length (s_tdata[34:3]),
    .data_byte    (s_tdata[42:35]),
    .idle         (idle),
    .ctl          (ctl),
    .round_byte   (round_byte)
  );

  fnvh_mix u_mix (
    .hash_in    (hash_state),
    .round_byte (round_byte),
    .hash_out   (mix_out)
  );

  always_comb begin
    priority if (ctl.load_basis) begin
      hash_next = fnvh_pkg::FNV_BASIS;
    end else if (ctl.load_saved) begin
      hash_next = saved_base;
    end else if (ctl.mix) begin
      hash_next = mix_out;
    end else begin
      hash_next = hash_state;
    end
    saved_base_next = ctl.save ? hash_state : saved_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_state <= fnvh_pkg::FNV_BASIS;
      saved_base <= fnvh_pkg::FNV_BASIS;
      m_tvalid   <= 1'b0;
    end else begin
      hash_state <= hash_next;
      saved_base <= saved_base_next;
      if (ctl.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    // hold the result until taken
    if (ctl.finish) begin
      hash_out <= hash_next;
    end
  end

  assign m_tdata = hash_out;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming FNV-1a 64-bit field hasher. A local
// model tracks the running hash and the checkpoint and predicts the hash
// returned for every accepted request. The checker compares each returned
// hash, in order, against those predictions. Stimulus runs in three parts:
// directed corner requests, framed records with random content, and random
// noise. The sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PRIME64     = (64'd1 << fnvh_pkg::FNV_PRIME_SHIFT) |
                                        64'(fnvh_pkg::FNV_PRIME_LOW);
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam int          TAIL_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // mode[2:0], field_length[34:3], data_byte[42:35], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // hash_value[63:0]

  // Model state and the hashes still owed by the block.
  logic [63:0] model_hash;
  logic [63:0] model_checkpoint;
  logic [63:0] pending_hashes[$];

  int errors        = 0;
  int requests_sent = 0;
  int headers_sent  = 0;
  int records_sent  = 0;
  int hashes_seen   = 0;
  int burst_left    = 0;
  bit sender_idles  = 1'b1;

  fnv1a64_field_hasher_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d hashes still pending", $realtime, pending_hashes.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * PRIME64;
  endfunction

  function automatic logic [63:0] fnv_mix_length(input logic [63:0] h,
                                                 input logic [fnvh_pkg::FIELD_LEN_W-1:0] len);
    logic [63:0] len64;
    logic [63:0] acc;
    len64 = 64'(len & fnvh_pkg::LEN_MASK);
    acc   = h;
    for (int k = 0; k < fnvh_pkg::LEN_BYTES; k++) begin
      acc = fnv_round(acc, len64[8*k +: 8]);
    end
    return acc;
  endfunction

  // Apply one request to the model and return the hash it should report.
  function automatic logic [63:0] predict_hash(input logic [2:0] mode,
                                               input logic [fnvh_pkg::FIELD_LEN_W-1:0] len,
                                               input logic [7:0] data);
    case (mode)
      fnvh_pkg::MODE_RESTART: model_hash = fnvh_pkg::FNV_BASIS;
      fnvh_pkg::MODE_RESTORE: model_hash = model_checkpoint;
      fnvh_pkg::MODE_SAVE:    model_checkpoint = model_hash;
      fnvh_pkg::MODE_ABSENT:  model_hash = fnv_round(model_hash, fnvh_pkg::TAG_ABSENT);
      fnvh_pkg::MODE_PRESENT: model_hash =
        fnv_mix_length(fnv_round(model_hash, fnvh_pkg::TAG_PRESENT), len);
      fnvh_pkg::MODE_PLAIN:   model_hash = fnv_mix_length(model_hash, len);
      fnvh_pkg::MODE_DATA:    model_hash = fnv_round(model_hash, data);
      default:                ;
    endcase
    return model_hash;
  endfunction

  // Receiver: alternate between styles of backpressure, including none.
  initial begin : receiver_stalls
    int style;
    int run;
    forever begin
      style = $urandom_range(0, 3);
      run   = $urandom_range(20, 200);
      repeat (run) begin
        @(posedge clk);
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 9) < 7);
          2:       m_tready <= ($urandom_range(0, 9) < 2);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      hashes_seen++;
      if (pending_hashes.size() == 0) begin
        errors++;
        $display("%0t: unexpected hash, expected none actual %h", $realtime, m_tdata);
      end else begin
        if (m_tdata !== pending_hashes[0]) begin
          errors++;
          $display("%0t: hash_value mismatch, expected %h actual %h",
                   $realtime, pending_hashes[0], m_tdata);
        end
        void'(pending_hashes.pop_front());
      end
    end
  end

  // Present one request and hold it until accepted; then maybe end the burst.
  task automatic send_request(input logic [2:0] mode,
                              input logic [fnvh_pkg::FIELD_LEN_W-1:0] len,
                              input logic [7:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, data, len, mode};
    do @(posedge clk); while (!s_tready);
    pending_hashes.push_back(predict_hash(mode, len, data));
    requests_sent++;
    if (mode == fnvh_pkg::MODE_PRESENT || mode == fnvh_pkg::MODE_PLAIN) headers_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (sender_idles) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every pending hash has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_corner_requests();
    sender_idles = 1'b0;
    // Restore before any save yields the offset basis.
    send_request(fnvh_pkg::MODE_RESTORE, 32'h0000_0000, 8'h00);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h00);
    send_request(fnvh_pkg::MODE_DATA,    32'hFFFF_FFFF, 8'hFF);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'hAA);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h55);
    send_request(fnvh_pkg::MODE_ABSENT,  32'hFFFF_FFFF, 8'hFF);
    send_request(fnvh_pkg::MODE_PRESENT, 32'h0000_0000, 8'hFF);
    send_request(fnvh_pkg::MODE_PRESENT, 32'hFFFF_FFFF, 8'h00);
    send_request(fnvh_pkg::MODE_PLAIN,   32'h0000_0000, 8'hFF);
    send_request(fnvh_pkg::MODE_PLAIN,   32'hFFFF_FFFF, 8'h00);
    send_request(fnvh_pkg::MODE_PLAIN,   32'h0000_0001, 8'h00);
    send_request(fnvh_pkg::MODE_SAVE,    32'h8000_0000, 8'h80);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h01);
    // Restart leaves the checkpoint alone.
    send_request(fnvh_pkg::MODE_RESTART, 32'h1234_5678, 8'h9A);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h80);
    send_request(fnvh_pkg::MODE_RESTORE, 32'h0000_0000, 8'h00);
    // The unused mode changes nothing.
    send_request(MODE_UNUSED,            32'hFFFF_FFFF, 8'hFF);
    send_request(MODE_UNUSED,            32'h0000_0000, 8'h00);
    // Bytes beyond the announced length are mixed anyway.
    send_request(fnvh_pkg::MODE_PLAIN,   32'h0000_0001, 8'h00);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h11);
    send_request(fnvh_pkg::MODE_DATA,    32'h0000_0000, 8'h22);
    send_request(fnvh_pkg::MODE_SAVE,    32'h0000_0000, 8'h00);
    send_request(fnvh_pkg::MODE_RESTART, 32'h0000_0000, 8'h00);
    sender_idles = 1'b1;
    wait_drained();
  endtask

  // Well-formed records with random content, some broken or mixed with noise.
  task automatic test_framed_records(input int target);
    int fields;
    int kind;
    int nbytes;
    logic [fnvh_pkg::FIELD_LEN_W-1:0] len;
    while (requests_sent < target) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      records_sent++;
      if ($urandom_range(0, 9) == 0) begin
        send_request(3'($urandom_range(0, 7)), $urandom, 8'($urandom));
        continue;
      end
      case ($urandom_range(0, 3))
        0, 1:    send_request(fnvh_pkg::MODE_RESTART, $urandom, 8'($urandom));
        2:       send_request(fnvh_pkg::MODE_RESTORE, $urandom, 8'($urandom));
        default: ;
      endcase
      fields = $urandom_range(1, 6);
      for (int f = 0; f < fields; f++) begin
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 15) == 0) ? fnvh_pkg::FIELD_LEN_W'($urandom)
                                            : fnvh_pkg::FIELD_LEN_W'($urandom_range(0, 6));
        nbytes = (len > 8) ? 8 : int'(len);
        // Break the framing now and then: too few or too many bytes.
        if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, 8);
        if (kind < 2) begin
          send_request(fnvh_pkg::MODE_ABSENT, $urandom, 8'($urandom));
          continue;
        end
        send_request((kind < 5) ? fnvh_pkg::MODE_PRESENT : fnvh_pkg::MODE_PLAIN,
                     len, 8'($urandom));
        repeat (nbytes) send_request(fnvh_pkg::MODE_DATA, $urandom, 8'($urandom));
      end
      if ($urandom_range(0, 2) == 0) begin
        send_request(fnvh_pkg::MODE_SAVE, $urandom, 8'($urandom));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_noise(input int count);
    sender_idles = 1'b1;
    repeat (count) send_request(3'($urandom_range(0, 7)), $urandom, 8'($urandom));
    wait_drained();
  endtask

  initial begin
    model_hash       = fnvh_pkg::FNV_BASIS;
    model_checkpoint = fnvh_pkg::FNV_BASIS;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_requests();
    test_framed_records(1050);
    test_random_noise(200);

    if (pending_hashes.size() != 0) begin
      errors++;
      $display("%0t: %0d hashes never returned", $realtime, pending_hashes.size());
    end
    $display("Sent %0d requests (%0d field headers) across %0d records and noise,",
             requests_sent, headers_sent, records_sent);
    $display("checked %0d returned hashes, %0d errors.", hashes_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== fnv1a64_field_hasher_unit.f =====
rtl/core/fnvh_pkg.sv
rtl/core/fnvh_mix.sv
rtl/core/fnvh_seq.sv
rtl/core/fnv1a64_field_hasher_unit.sv
tb/sv/testbench.sv
